// File: design/pdsd_pkg.sv
// Shared constants, types and command struct for the smoothed-derivative PD unit.
package pdsd_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned OUT_W          = 14;
  localparam int unsigned DERIV_W        = 24;
  localparam int unsigned MUL_B_W        = GAIN_W + 1;
  localparam int unsigned MUL_A_MIN_W    = 28;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned DERIV_TAPS_DEF = 4;

  localparam int          LIMIT_Q12      = 4096;
  localparam int          TIMESTEP_Q16   = 655;
  localparam int          DERIV_RATE     = 100;
  localparam int unsigned ALPHA_RESET    = 32768;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd3;

  typedef enum logic [2:0] {
    MUL_INT_A,
    MUL_INT_B,
    MUL_DER,
    MUL_P,
    MUL_AVG,
    MUL_D
  } mul_sel_e;

  typedef struct packed {
    logic     load_e;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_int;
    logic     upd_ring;
    logic     upd_p;
    logic     upd_avg;
    logic     load_out;
  } cmd_t;

endpackage

// File: design/pd_controller_smoothed_derivative_unit.sv
// Top level of the PD controller with smoothed derivative and reported integral.
//
//   channel   handshake                   payload
//   input     in_valid_i / in_stall_o     error_sample_i
//   output    out_valid_o / out_stall_i   drive_o, integral_sum_o, clamped_o
//   config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One error word steps from acceptance through states M1 to M7 and OUT to a
// loaded output word, and the next word is taken only back in IDLE: six
// products pass in turn through the one 28x17 multiplier, with integral, ring
// and average updates between them. The input is stalled while a word is in
// work. A held output word delays only the final load. Reset clears gains,
// sets alpha to one half and zeroes the integral, ring and smoothed average.
module pd_controller_smoothed_derivative_unit import pdsd_pkg::*; #(
  parameter int unsigned DERIV_TAPS = DERIV_TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] error_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OUT_W-1:0]  drive_o,
  output logic signed [OUT_W-1:0]  integral_sum_o,
  output logic                     clamped_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i
);

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  pdsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pdsd_datapath #(
    .DERIV_TAPS (DERIV_TAPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .error_sample_i (error_sample_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .drive_o        (drive_o),
    .integral_sum_o (integral_sum_o),
    .clamped_o      (clamped_o)
  );

endmodule

// File: design/pdsd_ctrl.sv
// Sequencer that steps one error word through the shared multiplier.
module pdsd_ctrl import pdsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_M5   = 4'd5;
  localparam logic [3:0] S_M6   = 4'd6;
  localparam logic [3:0] S_M7   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_INT_A;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_e = 1'b1;
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INT_A;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INT_B;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.upd_int = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DER;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.upd_ring = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_P;
        state_d = S_M5;
      end
      S_M5: begin
        cmd_o.upd_p   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_AVG;
        state_d = S_M6;
      end
      S_M6: begin
        cmd_o.upd_avg = 1'b1;
        state_d = S_M7;
      end
      S_M7: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/pdsd_datapath.sv
// Datapath: config registers, shared multiplier, integral, derivative ring and output word.
module pdsd_datapath import pdsd_pkg::*; #(
  parameter int unsigned DERIV_TAPS = DERIV_TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic signed [DATA_W-1:0] error_sample_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [GAIN_W-1:0]        cfg_data_i,
  output logic signed [OUT_W-1:0]  drive_o,
  output logic signed [OUT_W-1:0]  integral_sum_o,
  output logic                     clamped_o
);

  localparam int unsigned PTR_W  = (DERIV_TAPS > 1) ? $clog2(DERIV_TAPS) : 1;
  localparam int unsigned SHIFT  = $clog2(DERIV_TAPS + 1) - 1;
  localparam int unsigned TOT_W  = DERIV_W + $clog2(DERIV_TAPS);
  localparam int unsigned MEAN_W = TOT_W - SHIFT;
  localparam int unsigned A_W    = (MEAN_W + 1 > MUL_A_MIN_W) ? MEAN_W + 1 : MUL_A_MIN_W;
  localparam int unsigned PROD_W = A_W + MUL_B_W;
  localparam int unsigned ACC_W  = PROD_W - 24;
  localparam int unsigned P_W    = DATA_W + GAIN_W + 1 - 8;
  localparam int unsigned SUM_W  = PROD_W - 7;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(LIMIT_Q12);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(LIMIT_Q12);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(LIMIT_Q12);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(LIMIT_Q12);

  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, alpha_q;

  logic signed [DATA_W-1:0]  e_q;
  logic signed [DATA_W-1:0]  prev_q;
  logic signed [OUT_W-1:0]   integral_q;
  logic signed [DERIV_W-1:0] hist_q [DERIV_TAPS];
  logic [PTR_W-1:0]          ptr_q;
  logic signed [TOT_W-1:0]   total_q;
  logic signed [MEAN_W-1:0]  avg_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [PROD_W-1:0]  prod_q;

  logic signed [DATA_W:0]    e_sum, e_diff;
  logic signed [A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   int_acc;
  logic signed [OUT_W-1:0]   integral_d;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [MEAN_W-1:0]  mean;
  logic signed [SUM_W-1:0]   sum;
  logic signed [OUT_W-1:0]   drive_d;
  logic                      sat;

  assign e_sum  = (DATA_W + 1)'(e_q) + (DATA_W + 1)'(prev_q);
  assign e_diff = (DATA_W + 1)'(e_q) - (DATA_W + 1)'(prev_q);
  assign mean   = $signed(total_q[TOT_W-1:SHIFT]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_INT_A: begin
        mul_a = A_W'(e_sum);
        mul_b = MUL_B_W'(TIMESTEP_Q16);
      end
      MUL_INT_B: begin
        mul_a = $signed(prod_q[A_W-1:0]);
        mul_b = $signed({1'b0, gain_i_q});
      end
      MUL_DER: begin
        mul_a = A_W'(e_diff);
        mul_b = MUL_B_W'(DERIV_RATE);
      end
      MUL_P: begin
        mul_a = A_W'(e_q);
        mul_b = $signed({1'b0, gain_p_q});
      end
      MUL_AVG: begin
        mul_a = A_W'(mean) - A_W'(avg_q);
        mul_b = $signed({1'b0, alpha_q});
      end
      MUL_D: begin
        mul_a = A_W'(avg_q);
        mul_b = $signed({1'b0, gain_d_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    int_acc = ACC_W'(integral_q) + ACC_W'($signed(prod_q[PROD_W-1:25]));
    if (int_acc > ACC_MAX) begin
      integral_d = OUT_W'(LIMIT_Q12);
    end else if (int_acc < ACC_MIN) begin
      integral_d = -OUT_W'(LIMIT_Q12);
    end else begin
      integral_d = int_acc[OUT_W-1:0];
    end
  end

  assign deriv = $signed(prod_q[DERIV_W-1:0]);

  always_comb begin
    sum = SUM_W'(p_q) + SUM_W'($signed(prod_q[PROD_W-1:8]));
    sat = (sum > SUM_MAX) || (sum < SUM_MIN);
    if (sum > SUM_MAX) begin
      drive_d = OUT_W'(LIMIT_Q12);
    end else if (sum < SUM_MIN) begin
      drive_d = -OUT_W'(LIMIT_Q12);
    end else begin
      drive_d = sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      alpha_q  <= GAIN_W'(ALPHA_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_P: gain_p_q <= cfg_data_i;
        REG_GAIN_I: gain_i_q <= cfg_data_i;
        REG_GAIN_D: gain_d_q <= cfg_data_i;
        REG_ALPHA:  alpha_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      integral_q <= '0;
      ptr_q      <= '0;
      total_q    <= '0;
      avg_q      <= '0;
      for (int k = 0; k < DERIV_TAPS; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (cmd_i.upd_int) begin
        integral_q <= integral_d;
      end
      if (cmd_i.upd_ring) begin
        prev_q        <= e_q;
        hist_q[ptr_q] <= deriv;
        total_q       <= total_q + TOT_W'(deriv) - TOT_W'(hist_q[ptr_q]);
        if (ptr_q == PTR_W'(DERIV_TAPS - 1)) begin
          ptr_q <= '0;
        end else begin
          ptr_q <= ptr_q + PTR_W'(1);
        end
      end
      if (cmd_i.upd_avg) begin
        avg_q <= avg_q + MEAN_W'($signed(prod_q[PROD_W-1:16]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_e) begin
      e_q <= error_sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.upd_p) begin
      p_q <= $signed(prod_q[DATA_W+GAIN_W:8]);
    end
    if (cmd_i.load_out) begin
      drive_o        <= drive_d;
      integral_sum_o <= integral_q;
      clamped_o      <= sat;
    end
  end

endmodule
